FILE: hw/rtl/bre_pkg.sv
package bre_pkg;

  typedef struct packed {
    logic run_of_ones;
    logic last_for_item;
    logic end_of_stream;
    logic count_overflow;
  } run_flags_t;

endpackage

FILE: hw/rtl/bre_scan.sv
module bre_scan import bre_pkg::*; #(
  parameter int WORD_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [WORD_WIDTH-1:0] in_word,
  input  logic                  in_last,
  input  logic                  take,
  output logic                  s_valid,
  output logic [WORD_WIDTH-1:0] s_mask,
  output logic                  s_last
);

  logic                  s_valid_r;
  logic                  prev_bit_r;
  logic                  s_last_r;
  logic [WORD_WIDTH-1:0] s_mask_r;
  logic [WORD_WIDTH-1:0] change;
  logic                  accept;

  // Each lane flags a bit that differs from the bit scanned just before it.
  for (genvar i = 0; i < WORD_WIDTH; i++) begin : g_lane
    if (i == WORD_WIDTH - 1) begin : g_top
      assign change[i] = in_word[i] ^ prev_bit_r;
    end else begin : g_inner
      assign change[i] = in_word[i] ^ in_word[i+1];
    end
  end

  assign in_stall = s_valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r  <= 1'b0;
      prev_bit_r <= 1'b0;
    end else begin
      if (accept) begin
        s_valid_r  <= 1'b1;
        prev_bit_r <= in_last ? 1'b0 : in_word[0];
      end else if (take) begin
        s_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_mask_r <= change;
      s_last_r <= in_last;
    end
  end

  assign s_valid = s_valid_r;
  assign s_mask  = s_mask_r;
  assign s_last  = s_last_r;

endmodule

FILE: hw/rtl/bre_merge.sv
module bre_merge import bre_pkg::*; #(
  parameter int WORD_WIDTH      = 16,
  parameter int RUN_COUNT_WIDTH = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       s_valid,
  input  logic [WORD_WIDTH-1:0]      s_mask,
  input  logic                       s_last,
  output logic                       take,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [RUN_COUNT_WIDTH-1:0] out_run_length,
  output run_flags_t                 out_flags
);

  localparam int IDX_W = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;
  localparam int CNT_W = $clog2(WORD_WIDTH + 1);
  localparam int SUM_W = ((RUN_COUNT_WIDTH > CNT_W) ? RUN_COUNT_WIDTH : CNT_W) + 1;
  localparam logic [RUN_COUNT_WIDTH-1:0] CMAX = '1;

  logic                       busy_r;
  logic [WORD_WIDTH-1:0]      rem_r;
  logic                       last_r;
  logic [CNT_W-1:0]           rem_bits_r;
  logic                       cur_bit_r;
  logic [RUN_COUNT_WIDTH-1:0] run_count_r;
  logic                       run_sat_r;
  logic                       out_valid_r;
  logic [RUN_COUNT_WIDTH-1:0] out_len_r;
  run_flags_t                 out_flags_r;

  logic [IDX_W-1:0]           hi_idx;
  logic [WORD_WIDTH-1:0]      rem_clr;
  logic                       any;
  logic                       word_end;
  logic                       out_free;
  logic [CNT_W-1:0]           add_bits;
  logic [SUM_W-1:0]           sum;
  logic                       sum_ovf;
  logic [RUN_COUNT_WIDTH-1:0] run_len;
  logic                       run_ovf;
  logic [SUM_W-1:0]           tail_sum;
  logic                       tail_ovf;
  logic [RUN_COUNT_WIDTH-1:0] tail_len;
  logic                       emit;
  logic                       done;

  // The merge picks the highest pending bit change, one per cycle while the output is free.
  always_comb begin
    hi_idx = '0;
    for (int i = 0; i < WORD_WIDTH; i++) begin
      if (rem_r[i]) begin
        hi_idx = IDX_W'(i);
      end
    end
    for (int i = 0; i < WORD_WIDTH; i++) begin
      rem_clr[i] = rem_r[i] && (IDX_W'(i) != hi_idx);
    end
  end

  assign any      = |rem_r;
  assign word_end = (rem_clr == '0) && !last_r;
  assign out_free = !out_valid_r || !out_stall;

  assign add_bits = any ? (rem_bits_r - CNT_W'(1) - CNT_W'(hi_idx)) : rem_bits_r;
  assign sum      = SUM_W'(run_count_r) + SUM_W'(add_bits);
  assign sum_ovf  = sum > SUM_W'(CMAX);
  assign run_len  = sum_ovf ? CMAX : sum[RUN_COUNT_WIDTH-1:0];
  assign run_ovf  = run_sat_r || sum_ovf;

  assign tail_sum = SUM_W'(hi_idx) + SUM_W'(1);
  assign tail_ovf = tail_sum > SUM_W'(CMAX);
  assign tail_len = tail_ovf ? CMAX : tail_sum[RUN_COUNT_WIDTH-1:0];

  assign emit = busy_r && out_free && (any || last_r);
  assign done = busy_r && (any ? (out_free && word_end) : (!last_r || out_free));
  assign take = s_valid && (!busy_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cur_bit_r   <= 1'b0;
      run_count_r <= '0;
      run_sat_r   <= 1'b0;
      rem_bits_r  <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (emit && any) begin
        cur_bit_r <= ~cur_bit_r;
        if (word_end) begin
          run_count_r <= tail_len;
          run_sat_r   <= tail_ovf;
        end else begin
          run_count_r <= RUN_COUNT_WIDTH'(1);
          run_sat_r   <= 1'b0;
        end
      end else if (emit) begin
        cur_bit_r   <= 1'b0;
        run_count_r <= '0;
        run_sat_r   <= 1'b0;
      end else if (busy_r && !any && !last_r) begin
        run_count_r <= run_len;
        run_sat_r   <= run_ovf;
      end

      if (take) begin
        busy_r     <= 1'b1;
        rem_bits_r <= CNT_W'(WORD_WIDTH);
      end else begin
        if (done) begin
          busy_r <= 1'b0;
        end
        if (emit && any) begin
          rem_bits_r <= CNT_W'(hi_idx);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rem_r  <= s_mask;
      last_r <= s_last;
    end else if (emit && any) begin
      rem_r <= rem_clr;
    end
    if (emit) begin
      out_len_r                  <= run_len;
      out_flags_r.run_of_ones    <= cur_bit_r;
      out_flags_r.last_for_item  <= any ? word_end : 1'b1;
      out_flags_r.end_of_stream  <= !any;
      out_flags_r.count_overflow <= run_ovf;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_run_length = out_len_r;
  assign out_flags      = out_flags_r;

`ifndef ASSERT_OFF
  a_eos_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flags_r.end_of_stream |-> out_flags_r.last_for_item)
    else $error("end of stream result is not the last result of its item");

  a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flags_r.count_overflow |-> out_len_r == CMAX)
    else $error("overflowed run does not report the maximum length");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !any |=> !cur_bit_r && run_count_r == '0 && !run_sat_r)
    else $error("run state not cleared after stream flush");

  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_bits_r <= CNT_W'(WORD_WIDTH))
    else $error("remaining bit count exceeds the word width");
`endif

endmodule

FILE: hw/rtl/bit_run_length_encoder.sv
// Binary run-length encoder. Each input item is one word plus a last flag;
// the word is scanned from its top bit down and the lengths of alternating
// runs of equal bits come out, one run per output item, starting with a
// zeros run that may be empty. A word marked last also flushes the open run
// and starts a new stream. Both channels use valid and stall; an item moves
// at a clock edge with valid high and stall low.
// One lane per bit flags the bit changes as the word is taken into the scan
// register; the merge stage then emits one run per cycle into the output
// register, unless the output is stalled. A word's first run passes the scan
// register and the merge stage's registers before the output register. A
// word stays in the merge stage for one run per bit change, plus the flush
// of a last word, and a word without changes that is not last passes
// through without a run. The next word waits in the scan register meanwhile.
// Reset (rst_n low at a clock edge) empties all stages and restarts the
// stream with a zeros run of length zero. While out_stall is high a valid
// output item holds, the merge stage emits no run over it, and in_stall rises
// once the scan register holds a word waiting for the merge stage.
module bit_run_length_encoder import bre_pkg::*; #(
  parameter int WORD_WIDTH      = 16,
  parameter int RUN_COUNT_WIDTH = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [WORD_WIDTH-1:0]      in_sample_word,
  input  logic                       in_last_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [RUN_COUNT_WIDTH-1:0] out_run_length,
  output logic                       out_run_of_ones,
  output logic                       out_last_for_item,
  output logic                       out_end_of_stream,
  output logic                       out_count_overflow
);

  logic                  s_valid;
  logic [WORD_WIDTH-1:0] s_mask;
  logic                  s_last;
  logic                  take;
  run_flags_t            flags;

  bre_scan #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_sample_word),
    .in_last  (in_last_word),
    .take     (take),
    .s_valid  (s_valid),
    .s_mask   (s_mask),
    .s_last   (s_last)
  );

  bre_merge #(
    .WORD_WIDTH      (WORD_WIDTH),
    .RUN_COUNT_WIDTH (RUN_COUNT_WIDTH)
  ) u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .s_valid        (s_valid),
    .s_mask         (s_mask),
    .s_last         (s_last),
    .take           (take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_run_length (out_run_length),
    .out_flags      (flags)
  );

  assign out_run_of_ones    = flags.run_of_ones;
  assign out_last_for_item  = flags.last_for_item;
  assign out_end_of_stream  = flags.end_of_stream;
  assign out_count_overflow = flags.count_overflow;

endmodule

FILE: sim/bit_run_length_encoder_tb.sv
module bit_run_length_encoder_tb;
  import bre_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_W  = 16;
  localparam int COUNT_W = 15;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } word_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] length;
    run_flags_t         flags;
  } run_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [WORD_W-1:0]  in_sample_word = '0;
  logic               in_last_word = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COUNT_W-1:0] out_run_length;
  logic               out_run_of_ones;
  logic               out_last_for_item;
  logic               out_end_of_stream;
  logic               out_count_overflow;

  word_item_t         pending_words[$];
  run_t               expected_runs[$];
  word_item_t         next_word;
  run_t               want;
  int                 send_idle_pct = 29;
  int                 recv_idle_pct = 51;
  int                 mismatch_count = 0;

  logic               open_bit = 1'b0;
  logic [COUNT_W-1:0] open_count = '0;
  logic               open_saturated = 1'b0;

  bit_run_length_encoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_word    (in_sample_word),
    .in_last_word      (in_last_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_run_length    (out_run_length),
    .out_run_of_ones   (out_run_of_ones),
    .out_last_for_item (out_last_for_item),
    .out_end_of_stream (out_end_of_stream),
    .out_count_overflow(out_count_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic run_t open_run(input logic eos);
    run_t r;
    r.length               = open_count;
    r.flags.run_of_ones    = open_bit;
    r.flags.last_for_item  = 1'b0;
    r.flags.end_of_stream  = eos;
    r.flags.count_overflow = open_saturated;
    return r;
  endfunction

  function automatic void predict_runs(input logic [WORD_W-1:0] word, input logic last);
    run_t runs[$];
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (word[k] == open_bit) begin
        if (open_count == '1) begin
          open_saturated = 1'b1;
        end else begin
          open_count = open_count + 1'b1;
        end
      end else begin
        runs.push_back(open_run(1'b0));
        open_bit       = word[k];
        open_count     = COUNT_W'(1);
        open_saturated = 1'b0;
      end
    end
    if (last) begin
      runs.push_back(open_run(1'b1));
      open_bit       = 1'b0;
      open_count     = '0;
      open_saturated = 1'b0;
    end
    if (runs.size() > 0) begin
      runs[runs.size()-1].flags.last_for_item = 1'b1;
    end
    foreach (runs[i]) expected_runs.push_back(runs[i]);
  endfunction

  function automatic void add_word(input logic [WORD_W-1:0] word, input logic last);
    word_item_t it;
    it.word = word;
    it.last = last;
    pending_words.push_back(it);
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 5))
      0, 1: w = WORD_W'($urandom);
      2: w = '0;
      3: w = '1;
      4: w = ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000) ^ (16'hFFFF >> $urandom_range(0, 16));
      default: w = ($urandom_range(0, 1) ? 16'hAAAA : 16'h5555) ^ (16'h1 << $urandom_range(0, 15));
    endcase
    return w;
  endfunction

  function automatic void add_random_streams(input int count);
    int added;
    int len;
    added = 0;
    while (added < count) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) add_word(random_word(), i == len - 1);
      added += len;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_runs(in_sample_word, in_last_word);
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_word = pending_words.pop_front();
          in_sample_word <= next_word.word;
          in_last_word   <= next_word.last;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        if (expected_runs.size() == 0) begin
          $error("unexpected run: length %0d, ones %0b", out_run_length, out_run_of_ones);
          mismatch_count++;
        end else begin
          want = expected_runs.pop_front();
          if (want.length !== out_run_length) begin
            $error("run_length: expected %0d, got %0d", want.length, out_run_length);
            mismatch_count++;
          end
          if (want.flags.run_of_ones !== out_run_of_ones) begin
            $error("run_of_ones: expected %0b, got %0b", want.flags.run_of_ones,
                   out_run_of_ones);
            mismatch_count++;
          end
          if (want.flags.last_for_item !== out_last_for_item) begin
            $error("last_for_item: expected %0b, got %0b", want.flags.last_for_item,
                   out_last_for_item);
            mismatch_count++;
          end
          if (want.flags.end_of_stream !== out_end_of_stream) begin
            $error("end_of_stream: expected %0b, got %0b", want.flags.end_of_stream,
                   out_end_of_stream);
            mismatch_count++;
          end
          if (want.flags.count_overflow !== out_count_overflow) begin
            $error("count_overflow: expected %0b, got %0b", want.flags.count_overflow,
                   out_count_overflow);
            mismatch_count++;
          end
        end
      end
    end
  end

  task automatic drain_words();
    @(posedge clk);
    while (pending_words.size() > 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    // Short streams covering the extremes, the empty zeros run and the densest words.
    add_word(16'h0000, 1'b0);
    add_word(16'hFFFF, 1'b1);
    add_word(16'h0000, 1'b1);
    add_word(16'hFFFF, 1'b1);
    add_word(16'hAAAA, 1'b1);
    add_word(16'h5555, 1'b1);
    add_word(16'h8000, 1'b0);
    add_word(16'h0001, 1'b1);
    add_word(16'h7FFF, 1'b0);
    add_word(16'hFFFF, 1'b0);
    add_word(16'h0000, 1'b1);
    add_word(16'hAAAA, 1'b0);
    add_word(16'h5555, 1'b0);
    add_word(16'h1234, 1'b0);
    add_word(16'hFEDC, 1'b1);
    add_word(16'h0001, 1'b0);
    add_word(16'h8000, 1'b1);
    add_random_streams(51);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    drain_words();

    send_idle_pct = 51;
    recv_idle_pct = 29;
    add_random_streams(51);
    drain_words();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_streams(51);
    drain_words();

    while (expected_runs.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/bre_pkg.sv
hw/rtl/bre_scan.sv
hw/rtl/bre_merge.sv
hw/rtl/bit_run_length_encoder.sv
sim/bit_run_length_encoder_tb.sv
